// ----- rtl/sample_window_average_scaler_defines.svh -----
// Assertion macros used by the port-level checker of the window averager.
`ifndef SAMPLE_WINDOW_AVERAGE_SCALER_DEFINES_SVH
`define SAMPLE_WINDOW_AVERAGE_SCALER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWAS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swas assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swas assertion failed");

`endif

// ----- rtl/swas_pkg.sv -----
// Types, constants and codes shared by the window averager modules.
`default_nettype none

package swas_pkg;

    localparam int RING_DEPTH  = 16;
    localparam int SAMPLE_BITS = 12;

    // Fixed field widths
    localparam int WIN_W      = 5;
    localparam int READ_W     = 12;
    localparam int OUT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;

    // Shared divider: 28-bit dividend covers the 12x16 scale product
    localparam int DIV_N_W = 28;
    localparam int DIV_D_W = 12;
    localparam int DIV_S_W = 5;

    // Register reset values
    localparam logic [WIN_W-1:0]  WINDOW_RST   = 5'd8;
    localparam logic [READ_W-1:0] READ_MIN_RST = 12'd0;
    localparam logic [READ_W-1:0] READ_MAX_RST = 12'd4095;
    localparam logic [OUT_W-1:0]  OUT_MIN_RST  = 16'd0;
    localparam logic [OUT_W-1:0]  OUT_MAX_RST  = 16'd256;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WINDOW   = 3'd0,
        CFG_READ_MIN = 3'd1,
        CFG_READ_MAX = 3'd2,
        CFG_OUT_MIN  = 3'd3,
        CFG_OUT_MAX  = 3'd4
    } cfg_addr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RING,
        ST_AVG,
        ST_AVG_WAIT,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_LO,
        SEL_HI,
        SEL_MID
    } sel_t;

    typedef struct packed {
        logic               start;
        logic [DIV_S_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/swas_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none

module swas_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/swas_div.sv -----
// Restoring divider, one quotient bit per cycle, step count set per request.
`default_nettype none

module swas_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire swas_pkg::div_req_t               req,
    input  wire logic [swas_pkg::DIV_N_W-1:0]     dividend,
    input  wire logic [swas_pkg::DIV_D_W-1:0]     divisor,
    output logic      [swas_pkg::DIV_N_W-1:0]     quotient,
    output swas_pkg::div_stat_t                   stat
);

    logic [swas_pkg::DIV_N_W-1:0] work_reg;
    logic [swas_pkg::DIV_D_W-1:0] rem_reg;
    logic [swas_pkg::DIV_D_W-1:0] dvs_reg;
    logic [swas_pkg::DIV_S_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [swas_pkg::DIV_D_W:0]   part;
    logic [swas_pkg::DIV_D_W:0]   diff;
    logic                         ge;
    logic [swas_pkg::DIV_D_W-1:0] rem_next;

    always_comb
    begin
        part     = {rem_reg, work_reg[swas_pkg::DIV_N_W-1]};
        ge       = (part >= {1'b0, dvs_reg});
        diff     = part - {1'b0, dvs_reg};
        rem_next = ge ? diff[swas_pkg::DIV_D_W-1:0] : part[swas_pkg::DIV_D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == swas_pkg::DIV_S_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend is left-aligned so only its low 'steps' bits get processed;
    // after that many shifts the work register holds just the quotient.
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            work_reg <= dividend << (swas_pkg::DIV_S_W'(swas_pkg::DIV_N_W) - req.steps);
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[swas_pkg::DIV_N_W-2:0], ge};
            rem_reg  <= rem_next;
        end
    end

    assign quotient  = work_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/sample_window_average_scaler.sv -----
// Top level: ring-buffer moving average and linear range scaler.
//
// Usage:
//   s_* stream carries one word per conversion: sample and a reading to scale.
//   m_* stream returns one word per input word: latest sample, truncated
//   window average, scaled reading (signed Q8.8); tuser flags an empty range.
//   cfg_we/cfg_addr/cfg_wdata write the five registers; write them only while
//   no word is in flight. Writing window_size empties the ring.
// Flow:
//   One word at a time. The shared bit-serial divider does the average and
//   then the scale quotient. Empty window skips the average division; a
//   clamped or empty range skips the scale division.
// Reset: clears ring bookkeeping, the FSM and the output valid; registers
//   return to window 8, range 0..4095, output 0..1.0. Ring contents are not
//   cleared, they are only read after being written.
// Stall: the result sits in an output register; the next word is accepted
//   and processed meanwhile, then waits until that register frees.
`default_nettype none

module sample_window_average_scaler #(
    parameter int RING_DEPTH  = swas_pkg::RING_DEPTH,
    parameter int SAMPLE_BITS = swas_pkg::SAMPLE_BITS
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_we,
    input  wire logic [swas_pkg::CFG_ADDR_W-1:0]             cfg_addr,
    input  wire logic [swas_pkg::CFG_W-1:0]                  cfg_wdata,
    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    // sample, scale_operand
    input  wire logic [((SAMPLE_BITS+swas_pkg::READ_W+7)/8)*8-1:0] s_tdata,
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    // latest, average, scaled
    output logic [((2*SAMPLE_BITS+swas_pkg::OUT_W+7)/8)*8-1:0]     m_tdata,
    // range_error
    output logic [0:0]                                       m_tuser
);

    localparam int IDX_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int SUM_W       = SAMPLE_BITS + CNT_W;
    localparam int OUT_TDATA_W = ((2*SAMPLE_BITS+swas_pkg::OUT_W+7)/8)*8;
    localparam int RW          = swas_pkg::READ_W;
    localparam int OW          = swas_pkg::OUT_W;

    // Configuration
    logic [swas_pkg::WIN_W-1:0] window_reg;
    logic [RW-1:0]              rmin_reg;
    logic [RW-1:0]              rmax_reg;
    logic [OW-1:0]              omin_reg;
    logic [OW-1:0]              omax_reg;

    // Ring bookkeeping
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [SUM_W-1:0] sum_reg;

    swas_pkg::state_t state_reg, state_next;

    // Item payload
    logic [SAMPLE_BITS-1:0]      smp_reg;
    logic [RW-1:0]               op_reg;
    logic [SAMPLE_BITS-1:0]      avg_reg;
    logic [RW-1:0]               num_mag_reg;
    logic [RW-1:0]               den_mag_reg;
    logic [OW-1:0]               diff_mag_reg;
    logic                        neg_reg;
    logic                        err_reg;
    swas_pkg::sel_t              sel_reg;
    logic [swas_pkg::DIV_N_W-1:0] prod_reg;
    logic [OW-1:0]               res_reg;

    logic                        m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]      m_tdata_reg;
    logic                        m_tuser_reg;

    // Combinational
    logic [CNT_W-1:0]            win_eff;
    logic [IDX_W-1:0]            idx_cur;
    logic [CNT_W-1:0]            idx_inc;
    logic [IDX_W-1:0]            idx_nxt;
    logic                        full;
    logic [SAMPLE_BITS-1:0]      ram_rdata;
    logic                        ram_we;
    logic                        out_load;

    logic signed [RW:0]          num_s;
    logic signed [RW:0]          den_s;
    logic signed [RW:0]          nn;
    logic signed [RW:0]          dd;
    logic signed [OW:0]          span;
    logic [OW:0]                 span_mag;
    logic [OW-1:0]               q16;
    logic [OW:0]                 q17;
    logic [OW:0]                 res17;

    swas_pkg::div_req_t          div_req;
    swas_pkg::div_stat_t         div_stat;
    logic [swas_pkg::DIV_N_W-1:0] div_a;
    logic [swas_pkg::DIV_D_W-1:0] div_b;
    logic [swas_pkg::DIV_N_W-1:0] div_q;

    always_comb
    begin
        win_eff = (32'(window_reg) > RING_DEPTH) ? CNT_W'(RING_DEPTH) : CNT_W'(window_reg);
        idx_cur = (CNT_W'(idx_reg) >= win_eff) ? '0 : idx_reg;
        idx_inc = CNT_W'(idx_cur) + 1'b1;
        idx_nxt = (idx_inc >= win_eff) ? '0 : IDX_W'(idx_inc);
        full    = (fill_reg >= win_eff);
    end

    swas_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_cur),
        .wdata (smp_reg),
        .raddr (idx_cur),
        .rdata (ram_rdata)
    );

    // Scale operand prep: orient so the denominator is positive
    always_comb
    begin
        num_s    = $signed({1'b0, op_reg}) - $signed({1'b0, rmin_reg});
        den_s    = $signed({1'b0, rmax_reg}) - $signed({1'b0, rmin_reg});
        nn       = den_s[RW] ? -num_s : num_s;
        dd       = den_s[RW] ? -den_s : den_s;
        span     = $signed({omax_reg[OW-1], omax_reg}) - $signed({omin_reg[OW-1], omin_reg});
        span_mag = span[OW] ? (-span) : span;
        q16      = div_q[OW-1:0];
        q17      = neg_reg ? ((OW+1)'(0) - {1'b0, q16}) : {1'b0, q16};
        res17    = {omin_reg[OW-1], omin_reg} + q17;
    end

    // FSM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swas_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.steps = swas_pkg::DIV_S_W'(SUM_W);
        div_a         = swas_pkg::DIV_N_W'(sum_reg);
        div_b         = swas_pkg::DIV_D_W'(fill_reg);
        unique case (state_reg)
            swas_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = swas_pkg::ST_RING;
                end
            end
            swas_pkg::ST_RING:
            begin
                ram_we     = (win_eff != '0);
                state_next = swas_pkg::ST_AVG;
            end
            swas_pkg::ST_AVG:
            begin
                div_req.start = (fill_reg != '0);
                state_next    = (fill_reg != '0) ? swas_pkg::ST_AVG_WAIT : swas_pkg::ST_SCALE;
            end
            swas_pkg::ST_AVG_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = swas_pkg::ST_SCALE;
                end
            end
            swas_pkg::ST_SCALE:
            begin
                div_req.start = (sel_reg == swas_pkg::SEL_MID);
                div_req.steps = swas_pkg::DIV_S_W'(swas_pkg::DIV_N_W);
                div_a         = prod_reg;
                div_b         = swas_pkg::DIV_D_W'(den_mag_reg);
                state_next    = (sel_reg == swas_pkg::SEL_MID) ? swas_pkg::ST_SCALE_WAIT
                                                               : swas_pkg::ST_OUT;
            end
            swas_pkg::ST_SCALE_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = swas_pkg::ST_OUT;
                end
            end
            swas_pkg::ST_OUT:
            begin
                out_load = !m_tvalid_reg || m_tready;
                if (out_load)
                begin
                    state_next = swas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swas_pkg::ST_IDLE;
            end
        endcase
    end

    swas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // Configuration registers, ring bookkeeping and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= swas_pkg::WINDOW_RST;
            rmin_reg     <= swas_pkg::READ_MIN_RST;
            rmax_reg     <= swas_pkg::READ_MAX_RST;
            omin_reg     <= swas_pkg::OUT_MIN_RST;
            omax_reg     <= swas_pkg::OUT_MAX_RST;
            idx_reg      <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    swas_pkg::CFG_WINDOW:
                    begin
                        window_reg <= cfg_wdata[swas_pkg::WIN_W-1:0];
                        idx_reg    <= '0;
                        fill_reg   <= '0;
                        sum_reg    <= '0;
                    end
                    swas_pkg::CFG_READ_MIN: rmin_reg <= cfg_wdata[RW-1:0];
                    swas_pkg::CFG_READ_MAX: rmax_reg <= cfg_wdata[RW-1:0];
                    swas_pkg::CFG_OUT_MIN:  omin_reg <= cfg_wdata[OW-1:0];
                    swas_pkg::CFG_OUT_MAX:  omax_reg <= cfg_wdata[OW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            else if (ram_we)
            begin
                // Oldest entry read in the idle cycle drops out once the window is full
                sum_reg  <= sum_reg - (full ? SUM_W'(ram_rdata) : SUM_W'(0)) + SUM_W'(smp_reg);
                fill_reg <= full ? win_eff : fill_reg + 1'b1;
                idx_reg  <= idx_nxt;
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item datapath
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            smp_reg <= s_tdata[SAMPLE_BITS-1:0];
            op_reg  <= s_tdata[SAMPLE_BITS+RW-1:SAMPLE_BITS];
        end

        if (state_reg == swas_pkg::ST_RING)
        begin
            num_mag_reg  <= nn[RW-1:0];
            den_mag_reg  <= dd[RW-1:0];
            diff_mag_reg <= span_mag[OW-1:0];
            neg_reg      <= span[OW];
            err_reg      <= (den_s == '0);
            if ((den_s == '0) || nn[RW] || (nn == '0))
            begin
                sel_reg <= swas_pkg::SEL_LO;
            end
            else if (nn >= dd)
            begin
                sel_reg <= swas_pkg::SEL_HI;
            end
            else
            begin
                sel_reg <= swas_pkg::SEL_MID;
            end
        end

        if (state_reg == swas_pkg::ST_AVG)
        begin
            prod_reg <= swas_pkg::DIV_N_W'(num_mag_reg) * swas_pkg::DIV_N_W'(diff_mag_reg);
            if (fill_reg == '0)
            begin
                avg_reg <= smp_reg;
            end
        end

        if ((state_reg == swas_pkg::ST_AVG_WAIT) && div_stat.done)
        begin
            avg_reg <= div_q[SAMPLE_BITS-1:0];
        end

        if (state_reg == swas_pkg::ST_SCALE)
        begin
            case (sel_reg)
                swas_pkg::SEL_HI: res_reg <= omax_reg;
                swas_pkg::SEL_LO: res_reg <= omin_reg;
                default:          res_reg <= res_reg;
            endcase
        end

        if ((state_reg == swas_pkg::ST_SCALE_WAIT) && div_stat.done)
        begin
            res_reg <= res17[OW-1:0];
        end

        if (out_load)
        begin
            m_tdata_reg <= OUT_TDATA_W'({res_reg, avg_reg, smp_reg});
            m_tuser_reg <= err_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

// ----- rtl/swas_chk.sv -----
// Port-level checker for the window averager, bound to the top level.
`default_nettype none
`include "sample_window_average_scaler_defines.svh"

module swas_chk #(
    parameter int OUT_TDATA_W = 40
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]             m_tuser
);

    // A stalled result word holds
    `SWAS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // One word in flight: input closes right after an accept
    `SWAS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // A result never appears the cycle right after an accept
    `SWAS_ASSERT_SAME(a_min_latency, clk, rst_n, $rose(m_tvalid), !$past(s_tvalid && s_tready))

endmodule

bind sample_window_average_scaler swas_chk #(
    .OUT_TDATA_W (OUT_TDATA_W)
) u_swas_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
